@@ design/p10unpk_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// p10unpk_pkg
// Shared constants, types and helpers for the packed 10-bit pixel unpacker.
// ----------------------------------------------------------------------------
package p10unpk_pkg;

   localparam int MAX_WIDTH = 8192;
   localparam int MAX_ROWS  = 8192;

   localparam int BYTE_W    = 8;
   localparam int PIXEL_W   = 10;
   localparam int STORE_W   = 9;
   localparam int HELD_W    = 4;
   localparam int LEN_W     = 14;
   localparam int COLUMN_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W     = $clog2(MAX_ROWS);
   localparam int ACC_W     = STORE_W + BYTE_W;
   localparam int TOTAL_W   = HELD_W + 1;

   localparam logic [LEN_W-1:0]   MAX_WIDTH_LEN = LEN_W'(MAX_WIDTH);
   localparam logic [LEN_W-1:0]   MAX_ROWS_LEN  = LEN_W'(MAX_ROWS);
   localparam logic [TOTAL_W-1:0] PIXEL_BITS    = TOTAL_W'(PIXEL_W);
   localparam logic [TOTAL_W-1:0] BYTE_BITS     = TOTAL_W'(BYTE_W);

   // csr register indexes
   typedef enum logic [0:0] {
      CSR_ROW_WIDTH = 1'b0,
      CSR_ROW_COUNT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic               row_end;
      logic               frame_end;
   } result_type;

   // zero acts as one, anything above the maximum saturates
   function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v,
                                                  input logic [LEN_W-1:0] maxv);
      logic [LEN_W-1:0] r;
      if (v == '0) begin
         r = LEN_W'(1);
      end else if (v > maxv) begin
         r = maxv;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

@@ design/packed_10bit_pixel_unpacker_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// packed_10bit_pixel_unpacker_core
// Unpacks a little-endian bitstream of 10-bit pixels, one byte per transaction,
// with row and frame end marks on the pixel results.
// ----------------------------------------------------------------------------
// Takes one packed byte per clock while req_stall is low and gives zero or one
// 10-bit pixel for it. The bit accumulator, column and row counters update in
// the same cycle as the byte is accepted, so a byte can be accepted every
// clock unless stalled; results are registered in an output register backed
// by a one-entry skid buffer; req_stall rises only while that buffer is full.
// Rows start on byte boundaries: pad bits after a row's last pixel are
// dropped. row_width and row_count treat 0 as 1 and saturate at 8192; write
// them only while the block is idle.
module packed_10bit_pixel_unpacker_core (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    csr_write_enable,
   input  wire logic [0:0]                              csr_index,
   input  wire logic [p10unpk_pkg::LEN_W-1:0]           csr_write_data,
   input  wire logic                                    req_valid,
   output      logic                                    req_stall,
   input  wire logic [p10unpk_pkg::BYTE_W-1:0]          req_data_byte,
   output      logic                                    rsp_valid,
   input  wire logic                                    rsp_stall,
   output      logic [p10unpk_pkg::PIXEL_W-1:0]         rsp_pixel,
   output      logic                                    rsp_row_end,
   output      logic                                    rsp_frame_end
);

   logic [p10unpk_pkg::LEN_W-1:0]    row_width_ff;
   logic [p10unpk_pkg::LEN_W-1:0]    row_count_ff;
   logic [p10unpk_pkg::STORE_W-1:0]  bit_store_ff, bit_store_in;
   logic [p10unpk_pkg::HELD_W-1:0]   bits_held_ff, bits_held_in;
   logic [p10unpk_pkg::COLUMN_W-1:0] column_ff, column_in;
   logic [p10unpk_pkg::ROW_W-1:0]    row_ff, row_in;

   logic                             out_valid_ff, out_valid_in;
   p10unpk_pkg::result_type          out_data_ff, out_data_in;
   logic                             skid_valid_ff, skid_valid_in;
   p10unpk_pkg::result_type          skid_data_ff, skid_data_in;

   logic                             accept;
   logic                             out_taken;
   logic [p10unpk_pkg::ACC_W-1:0]    acc;
   logic [p10unpk_pkg::TOTAL_W-1:0]  total;
   logic                             emit;
   logic [p10unpk_pkg::LEN_W-1:0]    width_eff;
   logic [p10unpk_pkg::LEN_W-1:0]    rows_eff;
   logic                             last_col;
   logic                             last_row;
   p10unpk_pkg::result_type          result;

   assign accept    = req_valid && !req_stall;
   assign out_taken = out_valid_ff && !rsp_stall;

   // bit accumulator and counters
   always_comb begin
      acc       = {{p10unpk_pkg::BYTE_W{1'b0}}, bit_store_ff}
                | (p10unpk_pkg::ACC_W'(req_data_byte) << bits_held_ff);
      total     = {1'b0, bits_held_ff} + p10unpk_pkg::BYTE_BITS;
      emit      = total >= p10unpk_pkg::PIXEL_BITS;
      width_eff = p10unpk_pkg::clamp_len(row_width_ff, p10unpk_pkg::MAX_WIDTH_LEN);
      rows_eff  = p10unpk_pkg::clamp_len(row_count_ff, p10unpk_pkg::MAX_ROWS_LEN);
      last_col  = ({1'b0, column_ff} + p10unpk_pkg::LEN_W'(1)) >= width_eff;
      last_row  = ({1'b0, row_ff} + p10unpk_pkg::LEN_W'(1)) >= rows_eff;

      result.pixel     = acc[p10unpk_pkg::PIXEL_W-1:0];
      result.row_end   = last_col;
      result.frame_end = last_col && last_row;

      bit_store_in = bit_store_ff;
      bits_held_in = bits_held_ff;
      column_in    = column_ff;
      row_in       = row_ff;
      if (accept) begin
         if (!emit) begin
            bit_store_in = acc[p10unpk_pkg::STORE_W-1:0];
            bits_held_in = total[p10unpk_pkg::HELD_W-1:0];
         end else if (last_col) begin
            // pad bits of the row's final byte are dropped
            bit_store_in = '0;
            bits_held_in = '0;
            column_in    = '0;
            row_in       = last_row ? '0 : row_ff + p10unpk_pkg::ROW_W'(1);
         end else begin
            bit_store_in = p10unpk_pkg::STORE_W'(acc >> p10unpk_pkg::PIXEL_W);
            bits_held_in = p10unpk_pkg::HELD_W'(total - p10unpk_pkg::PIXEL_BITS);
            column_in    = column_ff + p10unpk_pkg::COLUMN_W'(1);
         end
      end
   end

   // output register with one-entry skid
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_taken) begin
         out_valid_in  = skid_valid_ff;
         out_data_in   = skid_data_ff;
         skid_valid_in = 1'b0;
      end
      if (accept && emit) begin
         if (!out_valid_in) begin
            out_valid_in = 1'b1;
            out_data_in  = result;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff  <= p10unpk_pkg::LEN_W'(1);
         row_count_ff  <= p10unpk_pkg::LEN_W'(1);
         bit_store_ff  <= '0;
         bits_held_ff  <= '0;
         column_ff     <= '0;
         row_ff        <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (p10unpk_pkg::csr_index_type'(csr_index))
               p10unpk_pkg::CSR_ROW_WIDTH: row_width_ff <= csr_write_data;
               p10unpk_pkg::CSR_ROW_COUNT: row_count_ff <= csr_write_data;
               default: ;
            endcase
         end
         bit_store_ff  <= bit_store_in;
         bits_held_ff  <= bits_held_in;
         column_ff     <= column_in;
         row_ff        <= row_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign req_stall     = skid_valid_ff;
   assign rsp_valid     = out_valid_ff;
   assign rsp_pixel     = out_data_ff.pixel;
   assign rsp_row_end   = out_data_ff.row_end;
   assign rsp_frame_end = out_data_ff.frame_end;

`ifndef SYNTHESIS
   // skid only fills behind a held output
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid buffer full while output register empty");

   a_held_bits_range: assert property (@(posedge clock) disable iff (reset)
      bits_held_ff <= p10unpk_pkg::HELD_W'(9))
      else $error("bit accumulator holds more than nine bits");

   a_frame_end_is_row_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_end |-> rsp_row_end)
      else $error("frame end without row end");

   a_row_end_clears: assert property (@(posedge clock) disable iff (reset)
      accept && emit && last_col |=> bits_held_ff == '0 && column_ff == '0)
      else $error("row end did not clear accumulator and column");
`endif

endmodule
`default_nettype wire
